@@ design/reversible_fifo_queue_unit_defines.svh @@
// Assertion macros shared by the checker of the queue unit.
`ifndef REVERSIBLE_FIFO_QUEUE_UNIT_DEFINES_SVH
`define REVERSIBLE_FIFO_QUEUE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RFQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/rfq_pkg.sv @@
`default_nettype none

package rfq_pkg;

	localparam int unsigned DEPTH = 64;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned CW    = $clog2(DEPTH + 1);
	localparam int unsigned DW    = 32;

	localparam logic [1:0] OP_ENQ  = 2'd0;
	localparam logic [1:0] OP_DISP = 2'd1;
	localparam logic [1:0] OP_REV  = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_OVF   = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic                 we;
		logic [AW-1:0]        waddr;
		logic signed [DW-1:0] wdata;
		logic [AW-1:0]        raddr_a;
		logic [AW-1:0]        raddr_b;
	} mem_req_t;

	typedef struct packed {
		logic signed [DW-1:0] rdata_a;
		logic signed [DW-1:0] rdata_b;
	} mem_rsp_t;

endpackage

`default_nettype wire

@@ design/rfq_ram.sv @@
`default_nettype none

module rfq_ram (
	input  wire logic              clk,
	input  wire rfq_pkg::mem_req_t req,
	output rfq_pkg::mem_rsp_t      rsp
);

	logic signed [rfq_pkg::DW-1:0] mem_q [rfq_pkg::DEPTH];
	logic signed [rfq_pkg::DW-1:0] rdata_a_q;
	logic signed [rfq_pkg::DW-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rdata_a_q <= mem_q[req.raddr_a];
		rdata_b_q <= mem_q[req.raddr_b];
	end

	assign rsp.rdata_a = rdata_a_q;
	assign rsp.rdata_b = rdata_b_q;

endmodule

`default_nettype wire

@@ design/rfq_ctrl.sv @@
`default_nettype none

module rfq_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [1:0]                  opcode,
	input  wire logic signed [rfq_pkg::DW-1:0] data_in,
	output logic                             strobe,
	output logic signed [rfq_pkg::DW-1:0]    data_out,
	output logic [1:0]                       status,
	output logic                             last,
	output rfq_pkg::mem_req_t                req,
	input  wire rfq_pkg::mem_rsp_t           rsp
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_DISP  = 6'b000010,
		ST_DRAIN = 6'b000100,
		ST_SW_RD = 6'b001000,
		ST_SW_WA = 6'b010000,
		ST_SW_WB = 6'b100000
	} state_t;

	state_t                        state_q;
	logic [rfq_pkg::CW-1:0]        count_q;
	logic [rfq_pkg::AW-1:0]        lo_q;
	logic [rfq_pkg::AW-1:0]        hi_q;
	logic signed [rfq_pkg::DW-1:0] tmp_q;
	logic                          disp_v_s1;
	logic                          last_s1;
	logic                          strobe_q;
	logic signed [rfq_pkg::DW-1:0] data_q;
	logic [1:0]                    status_q;
	logic                          last_q;

	logic       accept;
	logic       full;
	logic       lo_last;
	logic       sw_done;
	logic       res_v;
	logic [1:0] res_st;

	assign accept  = start && (state_q == ST_IDLE);
	assign full    = (count_q == rfq_pkg::CW'(rfq_pkg::DEPTH));
	assign lo_last = ((rfq_pkg::CW'(lo_q) + rfq_pkg::CW'(1)) == count_q);
	assign sw_done = (rfq_pkg::CW'(hi_q) <= (rfq_pkg::CW'(lo_q) + rfq_pkg::CW'(2)));

	always_comb begin
		req.we      = 1'b0;
		req.waddr   = lo_q;
		req.wdata   = tmp_q;
		req.raddr_a = lo_q;
		req.raddr_b = hi_q;
		res_v       = 1'b0;
		res_st      = rfq_pkg::STAT_OK;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (opcode)
						rfq_pkg::OP_ENQ: begin
							res_v = 1'b1;
							if (full) begin
								res_st = rfq_pkg::STAT_OVF;
							end else begin
								req.we    = 1'b1;
								req.waddr = count_q[rfq_pkg::AW-1:0];
								req.wdata = data_in;
							end
						end
						rfq_pkg::OP_DISP: begin
							if (count_q == '0) begin
								res_v  = 1'b1;
								res_st = rfq_pkg::STAT_EMPTY;
							end
						end
						rfq_pkg::OP_REV: begin
							if (count_q == '0) begin
								res_v  = 1'b1;
								res_st = rfq_pkg::STAT_EMPTY;
							end else if (count_q == rfq_pkg::CW'(1)) begin
								res_v = 1'b1;
							end
						end
						default: begin
							res_v = 1'b0;
						end
					endcase
				end
			end
			ST_SW_WA: begin
				req.we    = 1'b1;
				req.waddr = lo_q;
				req.wdata = rsp.rdata_b;
			end
			ST_SW_WB: begin
				req.we    = 1'b1;
				req.waddr = hi_q;
				req.wdata = tmp_q;
				res_v     = sw_done;
			end
			default: begin
				req.we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			disp_v_s1 <= 1'b0;
			strobe_q  <= 1'b0;
		end else begin
			disp_v_s1 <= (state_q == ST_DISP);
			strobe_q  <= res_v || disp_v_s1;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (opcode)
							rfq_pkg::OP_ENQ: begin
								if (!full) begin
									count_q <= count_q + rfq_pkg::CW'(1);
								end
							end
							rfq_pkg::OP_DISP: begin
								if (count_q != '0) begin
									state_q <= ST_DISP;
								end
							end
							rfq_pkg::OP_REV: begin
								if (count_q > rfq_pkg::CW'(1)) begin
									state_q <= ST_SW_RD;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_DISP: begin
					if (lo_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_IDLE;
				end
				ST_SW_RD: begin
					state_q <= ST_SW_WA;
				end
				ST_SW_WA: begin
					state_q <= ST_SW_WB;
				end
				ST_SW_WB: begin
					state_q <= sw_done ? ST_IDLE : ST_SW_RD;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lo_q <= '0;
			hi_q <= rfq_pkg::AW'(count_q - rfq_pkg::CW'(1));
		end else if (state_q == ST_DISP) begin
			lo_q <= lo_q + rfq_pkg::AW'(1);
		end else if ((state_q == ST_SW_WB) && !sw_done) begin
			lo_q <= lo_q + rfq_pkg::AW'(1);
			hi_q <= hi_q - rfq_pkg::AW'(1);
		end
		if (state_q == ST_SW_WA) begin
			tmp_q <= rsp.rdata_a;
		end
		last_s1  <= lo_last;
		data_q   <= disp_v_s1 ? rsp.rdata_a : '0;
		status_q <= disp_v_s1 ? rfq_pkg::STAT_OK : res_st;
		last_q   <= disp_v_s1 ? last_s1 : 1'b1;
	end

	assign busy     = (state_q != ST_IDLE);
	assign strobe   = strobe_q;
	assign data_out = data_q;
	assign status   = status_q;
	assign last     = last_q;

endmodule

`default_nettype wire

@@ design/reversible_fifo_queue_unit.sv @@
`default_nettype none

// Bounded queue of signed 32-bit words with enqueue, display and reverse requests.
// A request is taken at a rising edge where start is high and busy is low; opcode
// selects the operation and data_in carries the word for an enqueue.
// Every result is shown for exactly one cycle with strobe high, together with
// data_out, status and last; last marks the final result of a request.
// Enqueue never raises busy and its result appears in the cycle after the request.
// Display of n stored words keeps busy high through its read and drain states;
// each word passes the store read register and then the output register, so the
// first word comes later than an enqueue result; the rest follow one per cycle.
// Reverse swaps the outer pairs one at a time, each by a read of both entries and
// then one write to each, so busy stays high for floor(n / 2) swaps and the single
// result follows.
// An empty queue gives one result with the empty status for display or reverse.
// The unused opcode is taken but gives no result and changes nothing.
// Reset empties the queue at once; the stored words are not cleared because only
// written positions are ever read. The receiver cannot stall results.
module reversible_fifo_queue_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [1:0]                    opcode,
	input  wire logic signed [rfq_pkg::DW-1:0] data_in,
	output logic                               strobe,
	output logic signed [rfq_pkg::DW-1:0]      data_out,
	output logic [1:0]                         status,
	output logic                               last
);

	rfq_pkg::mem_req_t mem_req;
	rfq_pkg::mem_rsp_t mem_rsp;

	rfq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.opcode   (opcode),
		.data_in  (data_in),
		.strobe   (strobe),
		.data_out (data_out),
		.status   (status),
		.last     (last),
		.req      (mem_req),
		.rsp      (mem_rsp)
	);

	rfq_ram u_ram (
		.clk (clk),
		.req (mem_req),
		.rsp (mem_rsp)
	);

endmodule

`default_nettype wire

@@ design/rfq_chk.sv @@
`default_nettype none

`include "reversible_fifo_queue_unit_defines.svh"

module rfq_chk (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic [1:0]                    opcode,
	input wire logic                          strobe,
	input wire logic signed [rfq_pkg::DW-1:0] data_out,
	input wire logic [1:0]                    status,
	input wire logic                          last
);

	logic enq_taken;
	logic none_taken;
	logic status_only;
	logic enq_status;

	assign enq_taken   = start && !busy && (opcode == rfq_pkg::OP_ENQ);
	assign none_taken  = start && !busy && (opcode == rfq_pkg::OP_NONE);
	assign status_only = strobe && (status != rfq_pkg::STAT_OK);
	assign enq_status  = (status == rfq_pkg::STAT_OK) || (status == rfq_pkg::STAT_OVF);

	`RFQ_ASSERT_NOW(a_last_ends_busy, strobe, busy != last, "Last flag disagrees with busy.")
	`RFQ_ASSERT_NOW(a_status_only, status_only, (data_out == '0) && last, "Bad status result.")
	`RFQ_ASSERT_NEXT(a_enq_result, enq_taken, strobe && last && enq_status, "No enqueue result.")
	`RFQ_ASSERT_NEXT(a_none_silent, none_taken, !strobe && !busy, "Unused opcode caused activity.")

endmodule

bind reversible_fifo_queue_unit rfq_chk u_chk (.*);

`default_nettype wire
